/* rtl/core/ysr_pkg.sv */
// Shared types and constants for the YCbCr 4:2:2 to RGBA presenter.
package ysr_pkg;

  typedef struct packed {
    logic [31:0] source_base;
    logic [11:0] source_width;
    logic [11:0] source_height;
    logic [12:0] target_width;
    logic [12:0] target_height;
    logic [13:0] target_pitch;
  } cfg_t;

  typedef enum logic [2:0] {
    CFG_SOURCE_BASE   = 3'd0,
    CFG_SOURCE_WIDTH  = 3'd1,
    CFG_SOURCE_HEIGHT = 3'd2,
    CFG_TARGET_WIDTH  = 3'd3,
    CFG_TARGET_HEIGHT = 3'd4,
    CFG_TARGET_PITCH  = 3'd5
  } cfg_idx_t;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_REJECT    = 2'd1;
  localparam logic [1:0] ST_IDLE_DATA = 2'd2;

  // Divider geometry: 13-bit row or column times a 12-bit source dimension.
  localparam int DIV_DW = 25;
  localparam int DIV_QW = 12;

  typedef enum logic [2:0] {
    JOB_REJECT,
    JOB_EMPTY,
    JOB_START,
    JOB_IDLE_ERR,
    JOB_PAIR
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  y0;
    logic [7:0]  cb;
    logic [7:0]  y1;
    logic [7:0]  cr;
    logic [12:0] row;
    logic [12:0] col;
    logic [12:0] arow;
    logic [12:0] acol;
    logic        done;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CONV,
    B_DIV,
    B_ADDR,
    B_SUM,
    B_OUT
  } back_state_t;

endpackage

/* rtl/core/ysr_front.sv */
// Front end: accepts commands, tracks frame position and queues jobs.
module ysr_front #(
  parameter int MAX_SOURCE_DIM = 1024,
  parameter int MAX_TARGET_DIM = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ysr_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_command,
  input  logic [7:0]    in_luma_first,
  input  logic [7:0]    in_chroma_blue,
  input  logic [7:0]    in_luma_second,
  input  logic [7:0]    in_chroma_red,
  input  logic          q_full,
  output logic          q_push,
  output ysr_pkg::job_t q_job
);

  logic        active_r, active_nxt;
  logic [12:0] row_r, row_nxt;
  logic [12:0] col_r, col_nxt;
  logic        bad_cfg;
  logic        empty_frame;
  logic [12:0] ncol, nrow;
  logic        done;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    bad_cfg = (cfg.source_base == 32'd0) ||
              (cfg.source_width < 12'd2) ||
              (cfg.source_width > 12'(MAX_SOURCE_DIM)) ||
              (cfg.source_height < 12'd2) ||
              (cfg.source_height > 12'(MAX_SOURCE_DIM)) ||
              ({1'b0, cfg.target_width} > 14'(MAX_TARGET_DIM)) ||
              ({1'b0, cfg.target_height} > 14'(MAX_TARGET_DIM));
    empty_frame = (cfg.target_height == 13'd0) || (cfg.target_width < 13'd2);

    // Step two columns; wrap to the next row when the pair no longer fits.
    ncol = col_r + 13'd2;
    nrow = row_r;
    if (({1'b0, ncol} + 14'd1) >= {1'b0, cfg.target_width}) begin
      ncol = 13'd0;
      nrow = row_r + 13'd1;
    end
    done = (nrow >= cfg.target_height) ||
           (({1'b0, ncol} + 14'd1) >= {1'b0, cfg.target_width});

    active_nxt = active_r;
    row_nxt    = row_r;
    col_nxt    = col_r;

    q_job.y0   = in_luma_first;
    q_job.cb   = in_chroma_blue;
    q_job.y1   = in_luma_second;
    q_job.cr   = in_chroma_red;
    q_job.row  = row_r;
    q_job.col  = col_r;
    q_job.arow = 13'd0;
    q_job.acol = 13'd0;
    q_job.done = 1'b0;
    q_job.kind = ysr_pkg::JOB_IDLE_ERR;

    if (in_command == ysr_pkg::CMD_START) begin
      active_nxt = 1'b0;
      row_nxt    = 13'd0;
      col_nxt    = 13'd0;
      if (bad_cfg) begin
        q_job.kind = ysr_pkg::JOB_REJECT;
      end else if (empty_frame) begin
        q_job.kind = ysr_pkg::JOB_EMPTY;
      end else begin
        q_job.kind = ysr_pkg::JOB_START;
        active_nxt = 1'b1;
      end
    end else if (active_r) begin
      q_job.kind = ysr_pkg::JOB_PAIR;
      q_job.done = done;
      q_job.arow = nrow;
      q_job.acol = ncol;
      if (done) begin
        active_nxt = 1'b0;
        row_nxt    = 13'd0;
        col_nxt    = 13'd0;
      end else begin
        row_nxt = nrow;
        col_nxt = ncol;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      row_r    <= 13'd0;
      col_r    <= 13'd0;
    end else if (q_push) begin
      active_r <= active_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
    end
  end

endmodule

/* rtl/core/ysr_fifo.sv */
// Two-entry job queue between front and back end.
module ysr_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ysr_pkg::job_t push_job,
  input  logic          pop,
  output ysr_pkg::job_t head_job,
  output logic          full,
  output logic          empty
);

  ysr_pkg::job_t mem_r [2];
  logic          wptr_r;
  logic          rptr_r;
  logic [1:0]    cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign head_job = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (pop) begin
        rptr_r <= !rptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* rtl/core/ysr_div.sv */
// Restoring divider, one quotient bit per cycle.
module ysr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ysr_pkg::DIV_DW-1:0] dividend,
  input  logic [12:0]                divisor,
  output logic                       busy,
  output logic [ysr_pkg::DIV_QW-1:0] quotient
);

  localparam int CW = $clog2(ysr_pkg::DIV_DW + 1);

  logic [ysr_pkg::DIV_DW-1:0] q_r;
  logic [12:0]                rem_r;
  logic [12:0]                dvs_r;
  logic [CW-1:0]              cnt_r;
  logic                       busy_r;
  logic [13:0]                rem_sh;
  logic [13:0]                rem_sub;

  assign busy     = busy_r;
  assign quotient = q_r[ysr_pkg::DIV_QW-1:0];
  assign rem_sh   = {rem_r, q_r[ysr_pkg::DIV_DW-1]};
  assign rem_sub  = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= 13'd0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_r <= rem_sub[12:0];
        q_r   <= {q_r[ysr_pkg::DIV_DW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[12:0];
        q_r   <= {q_r[ysr_pkg::DIV_DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(ysr_pkg::DIV_DW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/ysr_back.sv */
// Back end: color conversion, offset and scaled fetch address per job.
module ysr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  ysr_pkg::cfg_t cfg,
  input  logic          q_empty,
  input  ysr_pkg::job_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_status,
  output logic          out_pixels_valid,
  output logic [31:0]   out_pixel_first,
  output logic [31:0]   out_pixel_second,
  output logic [25:0]   out_target_offset,
  output logic          out_fetch_valid,
  output logic [31:0]   out_fetch_address,
  output logic          out_frame_done
);

  ysr_pkg::back_state_t state_r, state_nxt;
  ysr_pkg::job_t        job_r;

  logic [1:0]  status_r;
  logic        pix_v_r;
  logic [31:0] pix0_r;
  logic [31:0] pix1_r;
  logic [25:0] offs_r;
  logic        fetch_v_r;
  logic [31:0] addr_r;
  logic        done_r;
  logic [11:0] sy_r;
  logic [11:0] sx_r;
  logic [23:0] prod_r;

  logic        need_addr;
  logic        div_start;
  logic        row_busy, col_busy;
  logic [11:0] row_q, col_q;
  logic [24:0] row_dvd, col_dvd;
  logic [26:0] offs_full;

  function automatic logic [7:0] sat_ch(logic signed [19:0] s);
    if (s[19]) begin
      return 8'd0;
    end else if (|s[18:16]) begin
      return 8'hFF;
    end
    return s[15:8];
  endfunction

  function automatic logic [31:0] to_argb(logic [7:0] y, logic [7:0] cb, logic [7:0] cr);
    logic signed [19:0] c, d, e, r, g, b;
    c = $signed({12'd0, y}) - 20'sd16;
    d = $signed({12'd0, cb}) - 20'sd128;
    e = $signed({12'd0, cr}) - 20'sd128;
    r = 20'sd298 * c + 20'sd409 * e + 20'sd128;
    g = 20'sd298 * c - 20'sd100 * d - 20'sd208 * e + 20'sd128;
    b = 20'sd298 * c + 20'sd516 * d + 20'sd128;
    return {8'hFF, sat_ch(r), sat_ch(g), sat_ch(b)};
  endfunction

  assign need_addr = (job_r.kind == ysr_pkg::JOB_START) ||
                     ((job_r.kind == ysr_pkg::JOB_PAIR) && !job_r.done);
  assign div_start = (state_r == ysr_pkg::B_CONV) && need_addr;
  assign row_dvd   = 25'(job_r.arow * cfg.source_height);
  assign col_dvd   = 25'(job_r.acol * cfg.source_width);
  assign offs_full = 27'(job_r.row * cfg.target_pitch) + {14'd0, job_r.col};

  ysr_div u_div_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (row_dvd),
    .divisor  (cfg.target_height),
    .busy     (row_busy),
    .quotient (row_q)
  );

  ysr_div u_div_col (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (col_dvd),
    .divisor  (cfg.target_width),
    .busy     (col_busy),
    .quotient (col_q)
  );

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    case (state_r)
      ysr_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = ysr_pkg::B_CONV;
        end
      end
      ysr_pkg::B_CONV: state_nxt = need_addr ? ysr_pkg::B_DIV : ysr_pkg::B_OUT;
      ysr_pkg::B_DIV: begin
        if (!row_busy && !col_busy) begin
          state_nxt = ysr_pkg::B_ADDR;
        end
      end
      ysr_pkg::B_ADDR: state_nxt = ysr_pkg::B_SUM;
      ysr_pkg::B_SUM:  state_nxt = ysr_pkg::B_OUT;
      ysr_pkg::B_OUT: begin
        if (out_ready) begin
          state_nxt = ysr_pkg::B_IDLE;
        end
      end
      default: state_nxt = ysr_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ysr_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ysr_pkg::B_IDLE: begin
        if (q_pop) begin
          job_r <= q_head;
        end
      end
      ysr_pkg::B_CONV: begin
        status_r  <= ysr_pkg::ST_OK;
        pix_v_r   <= 1'b0;
        pix0_r    <= 32'd0;
        pix1_r    <= 32'd0;
        offs_r    <= 26'd0;
        fetch_v_r <= 1'b0;
        addr_r    <= 32'd0;
        done_r    <= 1'b0;
        case (job_r.kind)
          ysr_pkg::JOB_REJECT:   status_r  <= ysr_pkg::ST_REJECT;
          ysr_pkg::JOB_EMPTY:    done_r    <= 1'b1;
          ysr_pkg::JOB_START:    fetch_v_r <= 1'b1;
          ysr_pkg::JOB_IDLE_ERR: status_r  <= ysr_pkg::ST_IDLE_DATA;
          ysr_pkg::JOB_PAIR: begin
            pix_v_r   <= 1'b1;
            pix0_r    <= to_argb(job_r.y0, job_r.cb, job_r.cr);
            pix1_r    <= to_argb(job_r.y1, job_r.cb, job_r.cr);
            offs_r    <= offs_full[25:0];
            fetch_v_r <= !job_r.done;
            done_r    <= job_r.done;
          end
          default: status_r <= ysr_pkg::ST_OK;
        endcase
      end
      ysr_pkg::B_DIV: begin
        sy_r <= row_q;
        sx_r <= {col_q[11:1], 1'b0};
      end
      ysr_pkg::B_ADDR: prod_r <= sy_r * cfg.source_width;
      ysr_pkg::B_SUM: begin
        addr_r <= cfg.source_base + {7'd0, prod_r, 1'b0} + {19'd0, sx_r, 1'b0};
      end
      default: begin
      end
    endcase
  end

  assign out_valid         = (state_r == ysr_pkg::B_OUT);
  assign out_status        = status_r;
  assign out_pixels_valid  = pix_v_r;
  assign out_pixel_first   = pix0_r;
  assign out_pixel_second  = pix1_r;
  assign out_target_offset = offs_r;
  assign out_fetch_valid   = fetch_v_r;
  assign out_fetch_address = addr_r;
  assign out_frame_done    = done_r;

  a_pix_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pixels_valid |-> out_pixel_first == 32'd0 &&
      out_pixel_second == 32'd0 && out_target_offset == 26'd0)
    else $error("pixel fields not cleared");

  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fetch_valid |-> out_fetch_address == 32'd0)
    else $error("fetch address not cleared");

  a_fetch_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fetch_valid |-> !out_frame_done)
    else $error("fetch issued on a frame-ending result");

  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ysr_pkg::ST_OK |->
      !out_pixels_valid && !out_fetch_valid && !out_frame_done)
    else $error("error result carries payload");

endmodule

/* rtl/core/yuv422_scaled_to_rgba.sv */
// Top level of the YCbCr 4:2:2 to RGBA frame presenter with nearest scaling.
//
// Channels: in_* carries a command (start frame, or one fetched Y0 Cb Y1 Cr
// pair); out_* returns exactly one result per accepted item; cfg_* writes the
// six frame registers by index (always ready, write only while idle).
// Flow: a valid start returns the first pair's fetch address (bad registers
// give a reject status, an empty target frame_done); each pair returns two
// ARGB words, the destination word offset and the next fetch address, or
// frame_done on the last pair of the frame; a pair outside a frame gives an
// idle-data status. Timing: a result without a fetch address passes the queue
// and the back-end states IDLE, CONV and OUT; one with an address also passes
// DIV, where the two 25-step restoring dividers (source line and source
// column) run, then ADDR and SUM; one job is in the back end at a time.
// A two-entry job queue separates the front end from the back end, so up to
// two items are taken while a result waits on a stalled receiver; after that
// in_ready drops until out_ready frees the output register.
// Reset: synchronous, active low; registers return to 0, 640, 480, 640, 480,
// 640, the frame is idle and the queue empty.
module yuv422_scaled_to_rgba #(
  parameter int MAX_SOURCE_DIM = 1024,
  parameter int MAX_TARGET_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_luma_first,
  input  logic [7:0]  in_chroma_blue,
  input  logic [7:0]  in_luma_second,
  input  logic [7:0]  in_chroma_red,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_pixels_valid,
  output logic [31:0] out_pixel_first,
  output logic [31:0] out_pixel_second,
  output logic [25:0] out_target_offset,
  output logic        out_fetch_valid,
  output logic [31:0] out_fetch_address,
  output logic        out_frame_done
);

  ysr_pkg::cfg_t cfg_r;
  ysr_pkg::job_t push_job;
  ysr_pkg::job_t head_job;
  logic          q_push, q_pop, q_full, q_empty;

  // Configuration registers: always accept a transfer.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_base   <= 32'd0;
      cfg_r.source_width  <= 12'd640;
      cfg_r.source_height <= 12'd480;
      cfg_r.target_width  <= 13'd640;
      cfg_r.target_height <= 13'd480;
      cfg_r.target_pitch  <= 14'd640;
    end else if (cfg_valid) begin
      case (cfg_index)
        ysr_pkg::CFG_SOURCE_BASE:   cfg_r.source_base   <= cfg_data;
        ysr_pkg::CFG_SOURCE_WIDTH:  cfg_r.source_width  <= cfg_data[11:0];
        ysr_pkg::CFG_SOURCE_HEIGHT: cfg_r.source_height <= cfg_data[11:0];
        ysr_pkg::CFG_TARGET_WIDTH:  cfg_r.target_width  <= cfg_data[12:0];
        ysr_pkg::CFG_TARGET_HEIGHT: cfg_r.target_height <= cfg_data[12:0];
        ysr_pkg::CFG_TARGET_PITCH:  cfg_r.target_pitch  <= cfg_data[13:0];
        default: begin
          // Drop writes beyond the register list.
        end
      endcase
    end
  end

  // Front end: classify commands and advance the frame position.
  ysr_front #(
    .MAX_SOURCE_DIM (MAX_SOURCE_DIM),
    .MAX_TARGET_DIM (MAX_TARGET_DIM)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_luma_first  (in_luma_first),
    .in_chroma_blue (in_chroma_blue),
    .in_luma_second (in_luma_second),
    .in_chroma_red  (in_chroma_red),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  // Job queue: hold up to two classified items.
  ysr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back end: convert, compute offsets and scaled addresses, drive results.
  ysr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_empty           (q_empty),
    .q_head            (head_job),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_pixels_valid  (out_pixels_valid),
    .out_pixel_first   (out_pixel_first),
    .out_pixel_second  (out_pixel_second),
    .out_target_offset (out_target_offset),
    .out_fetch_valid   (out_fetch_valid),
    .out_fetch_address (out_fetch_address),
    .out_frame_done    (out_frame_done)
  );

endmodule
